// ----- hdl/programmable_dfa_engine_defines.svh -----
// Assertion macros shared by the engine's modules.
// Both expect signals named clk and rst in the module that uses them.
`ifndef PROGRAMMABLE_DFA_ENGINE_DEFINES_SVH
`define PROGRAMMABLE_DFA_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dfa_pkg.sv -----
package dfa_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int SYM_W     = 8;
  localparam int STATE_W   = 8;
  localparam int SLOT_IN_W = 4;
  localparam int ASIZE_W   = 5;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_SLOTS_USED  = 1'b0;
  localparam logic REG_START_STATE = 1'b1;

  // Operation codes; the remaining codes are no-ops
  typedef enum logic [OP_W-1:0] {
    OP_STEP  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SET   = 3'd2,
    OP_RESET = 3'd3,
    OP_ALPHA = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [SYM_W-1:0]     symbol;
    logic [STATE_W-1:0]   from_state;
    logic [STATE_W-1:0]   to_state;
    logic                 accept_flag;
    logic [SLOT_IN_W-1:0] symbol_slot;
  } dfa_item_t;

  typedef struct packed {
    logic               accepting;
    logic               valid_res;
    logic [STATE_W-1:0] state_index;
    logic [STATE_W-1:0] active_state;
    logic               item_error;
  } dfa_result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_CLEAR,
    ST_ACC,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic commit;
    logic trans_rd;
    logic state_load;
    logic clear_wr;
    logic count_inc;
    logic acc_rd;
    logic out_load;
  } dfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            clear_last;
    logic            out_free;
  } dfa_status_t;

endpackage

// ----- hdl/dfa_cfg.sv -----
module dfa_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [dfa_pkg::ASIZE_W-1:0]    slots_used,
  output logic [dfa_pkg::STATE_W-1:0]    start_state
);
  import dfa_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used  <= '0;
      start_state <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SLOTS_USED:  slots_used  <= pwdata[ASIZE_W-1:0];
        REG_START_STATE: start_state <= pwdata[STATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_SLOTS_USED:  prdata = APB_DATA_W'(slots_used);
      REG_START_STATE: prdata = APB_DATA_W'(start_state);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hdl/dfa_ctrl.sv -----
`include "programmable_dfa_engine_defines.svh"

module dfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  dfa_pkg::dfa_status_t status,
  output dfa_pkg::dfa_cmd_t    cmd
);
  import dfa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.item_load = item_valid;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.commit = 1'b1;
        if (status.op == OP_STEP && status.ok) begin
          cmd.trans_rd = 1'b1;
          state_next   = ST_STEP;
        end else if (status.op == OP_ADD && status.ok) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_ACC;
        end
      end
      ST_STEP: begin
        cmd.state_load = 1'b1;
        state_next     = ST_ACC;
      end
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          cmd.count_inc = 1'b1;
          state_next    = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Only the idle state takes a new item
  assign item_stall = (state != ST_IDLE);

  `DFA_ASSERT_NEXT(a_take_to_exec, item_valid && !item_stall, state == ST_EXEC, "accepted item did not start")
  `DFA_ASSERT_NOW(a_step_after_read, state == ST_STEP, $past(cmd.trans_rd), "state load without table read")
  `DFA_ASSERT_NEXT(a_clear_holds, state == ST_CLEAR && !status.clear_last, state == ST_CLEAR, "row clear cut short")

endmodule

// ----- hdl/dfa_datapath.sv -----
`include "programmable_dfa_engine_defines.svh"

module dfa_datapath #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dfa_pkg::dfa_item_t            item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output dfa_pkg::dfa_result_t          res,
  input  logic [dfa_pkg::ASIZE_W-1:0]   slots_used,
  input  logic [dfa_pkg::STATE_W-1:0]   start_state,
  input  dfa_pkg::dfa_cmd_t             cmd,
  output dfa_pkg::dfa_status_t          status
);
  import dfa_pkg::*;

  // Only the first 2**SLOT_IN_W slots can ever be written
  localparam int NSLOT  = (MAX_SYMBOLS < (1 << SLOT_IN_W)) ? MAX_SYMBOLS : (1 << SLOT_IN_W);
  localparam int AL_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int COL_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int IDX_W  = $clog2(MAX_STATES);
  localparam int CNT_W  = $clog2(MAX_STATES + 1);
  localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = STATE_W + 1;

  dfa_item_t          cur_item;
  logic [STATE_W-1:0] cur;
  logic [CNT_W-1:0]   count;
  logic               invalid;
  logic               err;
  logic               added;
  logic [STATE_W-1:0] added_idx;
  logic [COL_W-1:0]   clr_col;

  logic [SYM_W-1:0]   alpha [NSLOT];
  logic [STATE_W-1:0] trans_mem [DEPTH];
  logic               acc_mem [MAX_STATES];
  logic [STATE_W-1:0] trans_rdata;
  logic               acc_rdata;

  logic [NSLOT-1:0]   hit;
  logic               hit_any;
  logic [COL_W-1:0]   slot;
  logic               cur_lt;
  logic               from_lt;
  logic               to_lt;
  logic               full;
  logic               ok;

  logic               trans_we;
  logic [ADDR_W-1:0]  trans_waddr;
  logic [STATE_W-1:0] trans_wdata;
  logic [ADDR_W-1:0]  trans_raddr;

  // Symbol match over the slots in use, lowest slot wins
  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      hit[i] = (ASIZE_W'(i) < slots_used) && (alpha[i] == cur_item.symbol);
    end
  end

  always_comb begin
    slot = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        slot = COL_W'(i);
      end
    end
  end

  assign hit_any = |hit;

  // Range checks against the number of states
  assign cur_lt  = CMP_W'(cur) < CMP_W'(count);
  assign from_lt = CMP_W'(cur_item.from_state) < CMP_W'(count);
  assign to_lt   = CMP_W'(cur_item.to_state) < CMP_W'(count);
  assign full    = (count == CNT_W'(MAX_STATES));

  always_comb begin
    unique case (cur_item.operation)
      OP_STEP: ok = cur_lt && hit_any;
      OP_ADD:  ok = !full;
      OP_SET:  ok = from_lt && to_lt && hit_any;
      default: ok = 1'b1;
    endcase
  end

  assign status.op         = cur_item.operation;
  assign status.ok         = ok;
  assign status.clear_last = (clr_col == COL_W'(MAX_SYMBOLS - 1));
  assign status.out_free   = !res_valid || !res_stall;

  // Item register
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      cur_item <= item;
    end
  end

  // Alphabet slots
  always_ff @(posedge clk) begin
    if (cmd.commit && cur_item.operation == OP_ALPHA
        && int'(cur_item.symbol_slot) < NSLOT) begin
      alpha[cur_item.symbol_slot[AL_W-1:0]] <= cur_item.symbol;
    end
  end

  // Transition table: one write port shared by set and row clear
  assign trans_we    = cmd.clear_wr || (cmd.commit && cur_item.operation == OP_SET && ok);
  assign trans_waddr = cmd.clear_wr
                     ? ADDR_W'(count[IDX_W-1:0]) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(clr_col)
                     : ADDR_W'(cur_item.from_state[IDX_W-1:0]) * ADDR_W'(MAX_SYMBOLS)
                       + ADDR_W'(slot);
  assign trans_wdata = cmd.clear_wr ? '0 : cur_item.to_state;
  assign trans_raddr = ADDR_W'(cur[IDX_W-1:0]) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[trans_waddr] <= trans_wdata;
    end
    if (cmd.trans_rd) begin
      trans_rdata <= trans_mem[trans_raddr];
    end
  end

  // Accept bits
  always_ff @(posedge clk) begin
    if (cmd.commit && cur_item.operation == OP_ADD && ok) begin
      acc_mem[count[IDX_W-1:0]] <= cur_item.accept_flag;
    end
    if (cmd.acc_rd) begin
      acc_rdata <= acc_mem[cur[IDX_W-1:0]];
    end
  end

  // Automaton state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      count   <= '0;
      invalid <= 1'b0;
    end else begin
      if (cmd.commit && cur_item.operation == OP_RESET) begin
        cur <= start_state;
      end else if (cmd.state_load) begin
        cur <= trans_rdata;
      end
      if (cmd.count_inc) begin
        count <= CNT_W'(count + 1'b1);
      end
      if (cmd.commit && !ok) begin
        invalid <= 1'b1;
      end
    end
  end

  // Per-item bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      err       <= !ok;
      added     <= (cur_item.operation == OP_ADD) && ok;
      added_idx <= STATE_W'(count);
      clr_col   <= '0;
    end else if (cmd.clear_wr) begin
      clr_col <= COL_W'(clr_col + 1'b1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.accepting    <= cur_lt && acc_rdata;
      res.valid_res    <= !invalid;
      res.state_index  <= added ? added_idx : cur;
      res.active_state <= cur;
      res.item_error   <= err;
    end
  end

  `DFA_ASSERT_NEXT(a_invalid_sticky, invalid, invalid, "invalid flag cleared")
  `DFA_ASSERT_NOW(a_error_flags, res_valid, !(res.item_error && res.valid_res), "error with valid result")
  `DFA_ASSERT_NOW(a_accept_exists, res_valid && res.accepting, CMP_W'(res.active_state) < CMP_W'(count), "accepting missing state")

endmodule

// ----- hdl/programmable_dfa_engine.sv -----
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  dfa_item_t
// res       out        res_valid/res_stall    dfa_result_t
// config    in         APB psel/penable       slots in use @0x0, start_state @0x4
//
// One item at a time. Step: table read, state load, accept-bit read, result.
// Add state: the new row is cleared one entry per cycle through the table's
// write port, then accept-bit read and result. Other operations, rejected
// steps and rejected adds go straight to accept-bit read and result. Reset
// clears state count, active state and the invalid flag. A stalled result
// holds the engine in its last step; a new item is taken while a result waits.
module programmable_dfa_engine #(
  parameter int MAX_STATES  = 256,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dfa_pkg::dfa_item_t             item,
  output logic                           res_valid,
  input  logic                           res_stall,
  output dfa_pkg::dfa_result_t           res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dfa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dfa_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import dfa_pkg::*;

  logic [ASIZE_W-1:0] slots_used;
  logic [STATE_W-1:0] start_state;
  dfa_cmd_t           cmd;
  dfa_status_t        status;

  // Configuration registers
  dfa_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .slots_used  (slots_used),
    .start_state (start_state)
  );

  // Sequencer
  dfa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Tables, state and result register
  dfa_datapath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .slots_used  (slots_used),
    .start_state (start_state),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dfa_pkg::*;

  localparam int STATE_CAP   = 256;
  localparam int NUM_SLOTS   = 16;
  localparam int ADD_CAP     = 200;     // random adds stop here; the full-table test fills the rest
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 30;      // longest op is add state
  localparam int IDLE_PAUSE  = 4;
  localparam int CYCLE_LIMIT = 600000;

  localparam logic [APB_ADDR_W-1:0] ADDR_ASIZE = {REG_SLOTS_USED, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_START = {REG_START_STATE, 2'b00};

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  dfa_item_t             item = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  dfa_result_t           res;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  programmable_dfa_engine dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the automaton
  logic [7:0] alpha_slots [0:NUM_SLOTS-1];
  logic [7:0] next_tab    [0:STATE_CAP*NUM_SLOTS-1];
  logic       acc_mark    [0:STATE_CAP-1];
  int         n_states = 0;
  logic [7:0] cur_st = '0;
  logic       sticky_bad = 1'b0;
  int         cfg_asize = 0;
  int         cfg_start = 0;

  dfa_result_t pending_outcomes [$];

  int n_fail = 0;
  int n_items = 0;
  int n_walked = 0;
  int n_rejects = 0;
  int n_cfg = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // Lowest alphabet slot in use that holds sym, or -1
  function automatic int slot_of(logic [7:0] sym);
    int used;
    used = (cfg_asize > NUM_SLOTS) ? NUM_SLOTS : cfg_asize;
    for (int i = 0; i < used; i++) begin
      if (alpha_slots[i] == sym) return i;
    end
    return -1;
  endfunction

  function automatic int used_slots();
    return (cfg_asize > NUM_SLOTS) ? NUM_SLOTS : cfg_asize;
  endfunction

  function automatic logic [7:0] known_symbol();
    return alpha_slots[$urandom_range(used_slots() - 1)];
  endfunction

  // Apply one item to the shadow automaton and return the outcome it should produce
  function automatic dfa_result_t dfa_advance(dfa_item_t it);
    dfa_result_t r;
    int          slot;
    logic        bad;
    logic        added;
    logic [7:0]  add_idx;
    bad = 1'b0;
    added = 1'b0;
    add_idx = '0;
    slot = slot_of(it.symbol);
    case (it.operation)
      OP_STEP: begin
        if (cur_st >= n_states || slot < 0) begin
          bad = 1'b1;
        end else begin
          cur_st = next_tab[cur_st * NUM_SLOTS + slot];
          n_walked++;
        end
      end
      OP_ADD: begin
        if (n_states >= STATE_CAP) begin
          bad = 1'b1;
        end else begin
          add_idx = n_states[7:0];
          acc_mark[add_idx] = it.accept_flag;
          for (int j = 0; j < NUM_SLOTS; j++) next_tab[add_idx * NUM_SLOTS + j] = '0;
          n_states++;
          added = 1'b1;
        end
      end
      OP_SET: begin
        if (it.from_state >= n_states || it.to_state >= n_states || slot < 0)
          bad = 1'b1;
        else
          next_tab[it.from_state * NUM_SLOTS + slot] = it.to_state;
      end
      OP_RESET: cur_st = cfg_start[7:0];
      OP_ALPHA: alpha_slots[it.symbol_slot] = it.symbol;
      default: ;
    endcase
    if (bad) begin
      sticky_bad = 1'b1;
      n_rejects++;
    end
    r.accepting    = (cur_st < n_states) ? acc_mark[cur_st] : 1'b0;
    r.valid_res    = ~sticky_bad;
    r.state_index  = added ? add_idx : cur_st;
    r.active_state = cur_st;
    r.item_error   = bad;
    return r;
  endfunction

  // Watchdog
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("programmable_dfa_engine test failed");
      $finish;
    end
  end

  // Result side: long hold-offs on request, otherwise a changing stall pattern
  int stall_pct = 0;
  int pat_left = 0;
  int hold_left = 0;
  int hold_request = 0;
  int hold_served = 0;
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left <= HOLD_LEN;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
    if (pat_left == 0) begin
      case ($urandom_range(3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 60;
        default: stall_pct <= 85;
      endcase
      pat_left <= $urandom_range(40, 300);
    end else begin
      pat_left <= pat_left - 1;
    end
  end

  task automatic cmp_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      n_fail++;
    end
  endtask

  // Compare each result transfer with the oldest outstanding outcome
  always @(posedge clk) begin : check_results
    dfa_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no outstanding item");
        n_fail++;
      end else begin
        want = pending_outcomes.pop_front();
        cmp_field("accepting", want.accepting, res.accepting);
        cmp_field("valid_res", want.valid_res, res.valid_res);
        cmp_field("state_index", want.state_index, res.state_index);
        cmp_field("active_state", want.active_state, res.active_state);
        cmp_field("item_error", want.item_error, res.item_error);
      end
    end
  end

  // One item transfer, with random gaps between bursts
  task automatic send_item(input dfa_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gaps_on && $urandom_range(9) < 6) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_outcomes.push_back(dfa_advance(it));
    n_items++;
  endtask

  function automatic dfa_item_t op_item(op_t op, logic [7:0] sym, logic [7:0] from_s,
                                        logic [7:0] to_s, logic acc, logic [3:0] slot);
    dfa_item_t it;
    it.operation   = op;
    it.symbol      = sym;
    it.from_state  = from_s;
    it.to_state    = to_s;
    it.accept_flag = acc;
    it.symbol_slot = slot;
    return it;
  endfunction

  // Stop offering items and wait until every outstanding result has come back
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers while idle and read them back
  task automatic set_regs(input int asize, input int start);
    logic [APB_DATA_W-1:0] rd;
    drain();
    apb_access(1'b1, ADDR_ASIZE, APB_DATA_W'(asize), rd);
    apb_access(1'b1, ADDR_START, APB_DATA_W'(start), rd);
    cfg_asize = asize & 5'h1F;
    cfg_start = start & 8'hFF;
    apb_access(1'b0, ADDR_ASIZE, '0, rd);
    if (rd !== APB_DATA_W'(cfg_asize)) begin
      $error("slots in use readback: expected %0d, actual %0d", cfg_asize, rd);
      n_fail++;
    end
    apb_access(1'b0, ADDR_START, '0, rd);
    if (rd !== APB_DATA_W'(cfg_start)) begin
      $error("start_state readback: expected %0d, actual %0d", cfg_start, rd);
      n_fail++;
    end
    n_cfg++;
  endtask

  // Random item biased toward well-formed traffic on the current machine
  task automatic make_traffic_item(output dfa_item_t it);
    int r;
    int used;
    it = dfa_item_t'($urandom);
    used = used_slots();
    r = $urandom_range(99);
    if (r < 45) begin
      it.operation = OP_STEP;
      if (used > 0 && $urandom_range(9) < 9) it.symbol = known_symbol();
    end else if (r < 53) begin
      it.operation = (n_states < ADD_CAP) ? OP_ADD : OP_STEP;
    end else if (r < 73) begin
      it.operation = OP_SET;
      if (n_states > 0 && $urandom_range(9) < 8) begin
        it.from_state = 8'($urandom_range(n_states - 1));
        it.to_state = 8'($urandom_range(n_states - 1));
        if (used > 0) it.symbol = known_symbol();
      end
    end else if (r < 81) begin
      it.operation = OP_RESET;
    end else if (r < 88) begin
      it.operation = OP_ALPHA;
    end else if (r < 94) begin
      it.operation = 3'($urandom_range(5, 7));
    end
  endtask

  // Slots 0..3 hold the edge symbols and a duplicate; no error seen yet
  task automatic test_alphabet_setup();
    send_item(op_item(OP_ALPHA, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_ALPHA, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd1));
    send_item(op_item(OP_ALPHA, 8'h5A, 8'h00, 8'hFF, 1'b0, 4'd2));
    send_item(op_item(OP_ALPHA, 8'h5A, 8'hFF, 8'h00, 1'b1, 4'd3));
    set_regs(4, 0);
  endtask

  // Step with a known symbol while no state exists
  task automatic test_empty_step();
    send_item(op_item(OP_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
  endtask

  // Small two-state machine walked through its edges
  task automatic test_build_and_walk();
    send_item(op_item(OP_ADD, 8'h00, 8'h00, 8'h00, 1'b1, 4'd0));
    send_item(op_item(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b0, 4'hF));
    send_item(op_item(OP_SET, 8'hFF, 8'd0, 8'd1, 1'b0, 4'd0));
    send_item(op_item(OP_SET, 8'h5A, 8'd1, 8'd0, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, 8'hFF, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, 8'h5A, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, 8'hFF, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(op_t'(3'd5), 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'hF));
    send_item(op_item(op_t'(3'd7), 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
  endtask

  // Unknown symbols, missing states and a missing start state
  task automatic test_rejects();
    send_item(op_item(OP_STEP, 8'h33, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_SET, 8'h00, 8'd200, 8'd0, 1'b0, 4'd0));
    send_item(op_item(OP_SET, 8'h00, 8'd0, 8'd2, 1'b0, 4'd0));
    send_item(op_item(OP_SET, 8'h33, 8'd0, 8'd1, 1'b0, 4'd0));
    set_regs(4, 255);
    send_item(op_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    set_regs(4, 1);
    send_item(op_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
  endtask

  // Result side held off for a long stretch while items keep coming
  task automatic test_backpressure();
    dfa_item_t it;
    drain();
    gaps_on = 1'b0;
    hold_request <= hold_request + 1;
    for (int k = 0; k < 12; k++) begin
      make_traffic_item(it);
      send_item(it);
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // Random traffic across several register settings
  task automatic test_random_traffic();
    dfa_item_t it;
    int asize;
    int start;
    int count;
    for (int s = 4; s < NUM_SLOTS; s++) begin
      it = dfa_item_t'($urandom);
      it.operation = OP_ALPHA;
      it.symbol_slot = 4'(s);
      send_item(it);
    end
    for (int p = 0; p < 6; p++) begin
      start = (n_states > 0) ? $urandom_range(n_states - 1) : 0;
      count = PHASE_ITEMS;
      case (p)
        0: begin asize = 16; start = 0; end
        1: asize = 1;
        2: begin asize = 0; count = 40; end
        3: begin asize = 16; start = 255; end
        default: asize = $urandom_range(1, 16);
      endcase
      set_regs(asize, start);
      for (int k = 0; k < count; k++) begin
        make_traffic_item(it);
        send_item(it);
      end
    end
  endtask

  // Fill the state table, overflow it, and walk from the last state
  task automatic test_full_table();
    dfa_item_t it;
    set_regs(16, 255);
    while (n_states < STATE_CAP) begin
      it = dfa_item_t'($urandom);
      it.operation = OP_ADD;
      send_item(it);
    end
    // one more add on the full table
    it = dfa_item_t'($urandom);
    it.operation = OP_ADD;
    send_item(it);
    send_item(op_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, alpha_slots[0], 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_SET, alpha_slots[0], 8'd255, 8'd255, 1'b1, 4'd0));
    send_item(op_item(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, alpha_slots[0], 8'h00, 8'h00, 1'b0, 4'd0));
    send_item(op_item(OP_STEP, alpha_slots[15], 8'h00, 8'h00, 1'b0, 4'd0));
  endtask

  task automatic finish_run();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      n_fail++;
    end
    $display("Run covered %0d item transfers, %0d successful steps, %0d rejected items,",
             n_items, n_walked, n_rejects);
    $display("%0d states built, %0d register settings, long result hold-off included.",
             n_states, n_cfg);
    if (n_fail == 0) begin
      $display("programmable_dfa_engine test passed");
    end else begin
      $display("programmable_dfa_engine test failed");
    end
    $finish;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alphabet_setup();
    test_empty_step();
    test_build_and_walk();
    test_rejects();
    test_random_traffic();
    test_backpressure();
    test_full_table();
    finish_run();
  end

endmodule
